[rtl/tena_pkg.sv]
// Package for the two-ended node allocator: sequencer states, request codes,
// half-word write enables and word layout constants.
// No dependencies; imported by the top level, tena_checker and tb_top.
`default_nettype none

package tena_pkg;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_ZLO, ST_IRV, ST_IRV1, ST_ILB, ST_ZHI,
    ST_G1, ST_G1R, ST_G1W, ST_F1,
    ST_FV0, ST_FV1, ST_FV2, ST_FV3, ST_FV4,
    ST_WSTART, ST_WP, ST_WPD, ST_WQ, ST_WQD,
    ST_WM2, ST_WM3, ST_WM4, ST_WMQ,
    ST_WEQ, ST_WEQ2, ST_WNX, ST_GFND,
    ST_GR0, ST_GR1, ST_GR2, ST_GR3, ST_GR4, ST_GR5,
    ST_S0, ST_S1, ST_S2, ST_SLT, ST_SIN, ST_SIN2, ST_SIN3,
    ST_SF0, ST_SF1, ST_SF2, ST_SF3,
    ST_DONE
  } state_e;

  localparam logic [2:0] REQ_INIT  = 3'd0;
  localparam logic [2:0] REQ_GET1  = 3'd1;
  localparam logic [2:0] REQ_GETV  = 3'd2;
  localparam logic [2:0] REQ_FREEV = 3'd3;
  localparam logic [2:0] REQ_FREE1 = 3'd4;
  localparam logic [2:0] REQ_SORT  = 3'd5;

  localparam logic [1:0] CFG_LOW_TOP   = 2'd0;
  localparam logic [1:0] CFG_HIGH_BOT  = 2'd1;
  localparam logic [1:0] CFG_STORE_TOP = 2'd2;
  localparam logic [1:0] CFG_HIGH_USE  = 2'd3;

  // Write enables for the info (upper) and link (lower) halves of a word.
  localparam logic [1:0] WE_NONE = 2'b00;
  localparam logic [1:0] WE_LO   = 2'b01;
  localparam logic [1:0] WE_HI   = 2'b10;
  localparam logic [1:0] WE_ALL  = 2'b11;

  localparam logic [15:0] EMPTY_MARK = 16'hFFFF;
  localparam logic [15:0] HALF_MAX   = 16'hFFFF;

endpackage

`default_nettype wire

[rtl/tena_store.sv]
// Word store of the allocator: one synchronous read port with registered
// data and one write port with separate enables for the two 16-bit halves.
// No dependencies.
`default_nettype none

module tena_store #(
  parameter int unsigned Depth = 65536,
  parameter int unsigned AddrW = 16
) (
  input  wire logic             clk_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [31:0]      rdata_o,
  input  wire logic [1:0]       we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [31:0]      wdata_i
);

  logic [31:0] ram_q [Depth];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i[1]) begin
      ram_q[waddr_i][31:16] <= wdata_i[31:16];
    end
    if (we_i[0]) begin
      ram_q[waddr_i][15:0] <= wdata_i[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= ram_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/two_ended_node_allocator.sv]
// Top level of the two-ended node allocator: request sequencer, pointer
// registers and result register around the word store.
// Depends on tena_pkg and tena_store.
`default_nettype none

//  Channel   Direction  Handshake                    Payload
//  ------    ---------  ---------------------------  ---------------------------------
//  request   in         in_valid_i / in_stall_o      req_type, node_words, node_addr
//  result    out        out_valid_o / out_stall_i    result_addr, status, used counts
//  config    in         cfg_we_i (no wait)           cfg_idx_i, cfg_wdata_i
//
// Each transaction is worked on alone by a sequencer that does at most one store
// read and one store write in any one state; read data comes back in the next
// cycle. Free single runs F1, get single G1 to G1W, free variable FV0 to FV4.
// Get variable and sort walk the free ring node by node, get variable growing
// the low region in GR0 to GR5; sort adds a pass per inserted node. Init sweeps
// low_static_top+1 plus store_top-high_static_bottom+1 words, one per cycle. Reset
// clears the counters and sets the pointers to their defaults; the store is not
// cleared. A result waiting under out_stall_i does not keep the next request out.

module two_ended_node_allocator #(
  parameter int unsigned STORE_WORDS = 65536,
  parameter int unsigned GROW_CHUNK  = 1000
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [15:0] node_words_i,
  input  wire logic [15:0] node_addr_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      result_addr_o,
  output logic             status_o,
  output logic [16:0]      variable_used_o,
  output logic [16:0]      single_used_o
);
  import tena_pkg::*;

  localparam int unsigned AW = $clog2(STORE_WORDS);
  // Walk and sort step counters must hold twice the store size.
  localparam int unsigned CW = $clog2(2 * STORE_WORDS + 1);

  // Store index of a 16-bit address: the address modulo the store size. The
  // quotient is below 16, so four compare and subtract steps suffice.
  function automatic logic [AW-1:0] ix(input logic [15:0] a);
    logic [19:0] rem;
    rem = {4'b0, a};
    for (int k = 3; k >= 0; k--) begin
      if (rem >= (20'(STORE_WORDS) << k)) begin
        rem = rem - (20'(STORE_WORDS) << k);
      end
    end
    return rem[AW-1:0];
  endfunction

  state_e state_q, state_d;

  // Configuration registers.
  logic [11:0] lst_q;
  logic [15:0] hsb_q, stop_q;
  logic [7:0]  hsu_q;

  // Allocator state.
  logic [15:0] avail_q, avail_d, top_q, top_d, lb_q, lb_d, hb_q, hb_d, rov_q, rov_d;
  logic [16:0] vc_q, vc_d, sc_q, sc_d;

  // Working registers of the current transaction.
  logic [15:0] s_q, s_d, a_q, a_d, p_q, p_d, q_q, q_d, t_q, t_d, l_q, l_d;
  logic [15:0] k_q, k_d, old_q, old_d, res_q, res_d;
  logic        sort_q, sort_d, stat_q, stat_d;
  logic [CW-1:0] budget_q, budget_d, outer_q, outer_d, ins_q, ins_d, n_q, n_d;

  // Result register.
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_res_q;
  logic        out_stat_q;
  logic [16:0] out_vc_q, out_sc_q;
  logic        out_load;

  // Store port.
  logic        mem_re;
  logic [15:0] mem_raddr, mem_waddr;
  logic [1:0]  mem_we;
  logic [31:0] mem_wdata, mem_rdata;
  logic [15:0] rd_hi, rd_lo;

  tena_store #(
    .Depth (STORE_WORDS),
    .AddrW (AW)
  ) u_store (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (ix(mem_raddr)),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (ix(mem_waddr)),
    .wdata_i (mem_wdata)
  );

  assign rd_hi = mem_rdata[31:16];
  assign rd_lo = mem_rdata[15:0];

  // Decisions shared by the next-state and the action logic.
  logic        in_acc, rd_empty, bud_zero, r_gt, r_eq, rp_ne, avail_nz, top_can;
  logic        hb_full, grow_ok, outer_over, n_over;
  logic [17:0] r_s, p1_s, grow_sum, mid_sum, tgt;
  logic [15:0] rv, ls_plus;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign rd_empty = rd_lo == EMPTY_MARK;
  assign bud_zero = budget_q == '0;
  assign r_s      = {2'b0, q_q} - {2'b0, s_q};
  assign p1_s     = {2'b0, p_q} + 18'd1;
  // In a merge-only pass no node is ever taken.
  assign r_gt     = !sort_q && ($signed(r_s) > $signed(p1_s));
  assign r_eq     = !sort_q && (r_s == {2'b0, p_q});
  assign rp_ne    = rd_lo != p_q;
  assign avail_nz = avail_q != 16'd0;
  assign top_can  = {1'b0, top_q} < 17'(STORE_WORDS - 1);
  assign hb_full  = {1'b0, hb_q} <= ({1'b0, lb_q} + 17'd1);
  assign grow_ok  = (({1'b0, lb_q} + 17'd2) < {1'b0, hb_q}) &&
                    (({1'b0, lb_q} + 17'd2) <= {1'b0, HALF_MAX});
  assign grow_sum = {2'b0, lb_q} + 18'(GROW_CHUNK);
  assign mid_sum  = ({2'b0, lb_q} + {2'b0, hb_q} + 18'd2) >> 1;
  assign tgt      = (grow_sum < {2'b0, hb_q}) ? grow_sum :
                    ((mid_sum > {2'b0, HALF_MAX}) ? {2'b0, HALF_MAX} : mid_sum);
  assign outer_over = (outer_q + CW'(1)) > CW'(STORE_WORDS);
  assign n_over     = (n_q + CW'(1)) > ins_q;
  assign rv         = {4'b0, lst_q} + 16'd1;
  assign ls_plus    = {4'b0, lst_q};
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (req_type_i)
            REQ_INIT:  state_d = ST_ZLO;
            REQ_GET1:  state_d = ST_G1;
            REQ_GETV:  state_d = ST_WSTART;
            REQ_FREEV: state_d = ST_FV0;
            REQ_FREE1: state_d = ST_F1;
            REQ_SORT:  state_d = ST_WSTART;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_ZLO:  state_d = (k_q == ls_plus) ? ST_IRV : ST_ZLO;
      ST_IRV:  state_d = ST_IRV1;
      ST_IRV1: state_d = ST_ILB;
      ST_ILB:  state_d = (hsb_q <= stop_q) ? ST_ZHI : ST_DONE;
      ST_ZHI:  state_d = (k_q == stop_q) ? ST_DONE : ST_ZHI;
      ST_G1: begin
        if (avail_nz) begin
          state_d = ST_G1R;
        end else if (top_can || !hb_full) begin
          state_d = ST_G1W;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_G1R:  state_d = ST_G1W;
      ST_G1W:  state_d = ST_DONE;
      ST_F1:   state_d = ST_DONE;
      ST_FV0:  state_d = ST_FV1;
      ST_FV1:  state_d = ST_FV2;
      ST_FV2:  state_d = ST_FV3;
      ST_FV3:  state_d = ST_FV4;
      ST_FV4:  state_d = ST_DONE;
      ST_WSTART: state_d = ST_WP;
      ST_WP:   state_d = ST_WPD;
      ST_WPD:  state_d = ST_WQ;
      ST_WQ:   state_d = ST_WQD;
      ST_WQD: begin
        if (rd_empty) begin
          state_d = bud_zero ? ST_DONE : ST_WM2;
        end else if (r_gt) begin
          state_d = ST_GFND;
        end else if (r_eq) begin
          state_d = ST_WEQ;
        end else begin
          state_d = ST_WNX;
        end
      end
      ST_WM2:  state_d = ST_WM3;
      ST_WM3:  state_d = ST_WM4;
      ST_WM4:  state_d = ST_WMQ;
      ST_WMQ:  state_d = ST_WQ;
      ST_WEQ:  state_d = rp_ne ? ST_WEQ2 : ST_WNX;
      ST_WEQ2: state_d = ST_GFND;
      ST_WNX: begin
        if (bud_zero) begin
          state_d = ST_DONE;
        end else if (rd_lo == rov_q) begin
          state_d = sort_q ? ST_S0 : ST_GR0;
        end else begin
          state_d = ST_WP;
        end
      end
      ST_GFND: state_d = ST_DONE;
      ST_GR0:  state_d = grow_ok ? ST_GR1 : ST_DONE;
      ST_GR1:  state_d = ST_GR2;
      ST_GR2:  state_d = ST_GR3;
      ST_GR3:  state_d = ST_GR4;
      ST_GR4:  state_d = ST_GR5;
      ST_GR5:  state_d = ST_WSTART;
      ST_S0:   state_d = ST_S1;
      ST_S1:   state_d = ST_S2;
      ST_S2: begin
        if (p_q == old_q) begin
          state_d = ST_SF0;
        end else if (outer_over) begin
          state_d = ST_DONE;
        end else begin
          state_d = (p_q < rov_q) ? ST_SLT : ST_SIN;
        end
      end
      ST_SLT:  state_d = ST_S2;
      ST_SIN: begin
        if (rd_lo < p_q) begin
          state_d = n_over ? ST_DONE : ST_SIN;
        end else begin
          state_d = ST_SIN2;
        end
      end
      ST_SIN2: state_d = ST_SIN3;
      ST_SIN3: state_d = ST_S2;
      ST_SF0:  state_d = ST_SF1;
      ST_SF1: begin
        if (rd_lo != HALF_MAX) begin
          state_d = n_over ? ST_DONE : ST_SF2;
        end else begin
          state_d = ST_SF3;
        end
      end
      ST_SF2:  state_d = ST_SF1;
      ST_SF3:  state_d = ST_DONE;
      ST_DONE: state_d = out_load ? ST_IDLE : ST_DONE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Store accesses and register updates of each state.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = p_q;
    mem_we    = WE_NONE;
    mem_waddr = p_q;
    mem_wdata = 32'd0;
    avail_d = avail_q; top_d = top_q; lb_d = lb_q; hb_d = hb_q; rov_d = rov_q;
    vc_d = vc_q; sc_d = sc_q;
    s_d = s_q; a_d = a_q; p_d = p_q; q_d = q_q; t_d = t_q; l_d = l_q;
    k_d = k_q; old_d = old_q; res_d = res_q; sort_d = sort_q; stat_d = stat_q;
    budget_d = budget_q; outer_d = outer_q; ins_d = ins_q; n_d = n_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          s_d    = (node_words_i < 16'd2) ? 16'd2 : node_words_i;
          a_d    = node_addr_i;
          sort_d = req_type_i == REQ_SORT;
          res_d  = 16'd0;
          stat_d = 1'b0;
          k_d    = 16'd0;
        end
      end
      ST_ZLO: begin
        mem_we = WE_ALL; mem_waddr = k_q;
        k_d = k_q + 16'd1;
      end
      ST_IRV: begin
        mem_we = WE_ALL; mem_waddr = rv;
        mem_wdata = {16'(GROW_CHUNK), EMPTY_MARK};
        rov_d = rv;
      end
      ST_IRV1: begin
        mem_we = WE_ALL; mem_waddr = rv + 16'd1; mem_wdata = {rv, rv};
        lb_d = rv + 16'(GROW_CHUNK);
      end
      ST_ILB: begin
        mem_we = WE_ALL; mem_waddr = lb_q;
        k_d     = hsb_q;
        avail_d = 16'd0;
        top_d   = stop_q;
        hb_d    = hsb_q;
        vc_d    = {5'b0, lst_q} + 17'd1;
        sc_d    = {9'b0, hsu_q};
      end
      ST_ZHI: begin
        mem_we = WE_ALL; mem_waddr = k_q;
        k_d = k_q + 16'd1;
      end
      ST_G1: begin
        if (avail_nz) begin
          mem_re = 1'b1; mem_raddr = avail_q;
          p_d = avail_q;
        end else if (top_can) begin
          top_d = top_q + 16'd1;
          p_d   = top_q + 16'd1;
        end else if (!hb_full) begin
          hb_d = hb_q - 16'd1;
          p_d  = hb_q - 16'd1;
        end else begin
          stat_d = 1'b1;
        end
      end
      ST_G1R: avail_d = rd_lo;
      ST_G1W: begin
        mem_we = WE_LO; mem_waddr = p_q;
        sc_d  = sc_q + 17'd1;
        res_d = p_q;
      end
      ST_F1: begin
        mem_we = WE_LO; mem_waddr = a_q; mem_wdata = {16'd0, avail_q};
        avail_d = a_q;
        sc_d    = sc_q - 17'd1;
      end
      ST_FV0: begin
        mem_we = WE_ALL; mem_waddr = a_q; mem_wdata = {s_q, EMPTY_MARK};
      end
      ST_FV1: begin
        mem_re = 1'b1; mem_raddr = rov_q + 16'd1;
      end
      ST_FV2: begin
        mem_we = WE_ALL; mem_waddr = a_q + 16'd1; mem_wdata = {rd_hi, rov_q};
        q_d = rd_hi;
      end
      ST_FV3: begin
        mem_we = WE_HI; mem_waddr = rov_q + 16'd1; mem_wdata = {a_q, 16'd0};
      end
      ST_FV4: begin
        mem_we = WE_LO; mem_waddr = q_q + 16'd1; mem_wdata = {16'd0, a_q};
        vc_d = vc_q - {1'b0, s_q};
      end
      ST_WSTART: begin
        p_d      = rov_q;
        budget_d = CW'(2 * STORE_WORDS);
      end
      ST_WP: begin
        mem_re = 1'b1; mem_raddr = p_q;
      end
      ST_WPD: q_d = p_q + rd_hi;
      ST_WQ: begin
        mem_re = 1'b1; mem_raddr = q_q;
      end
      ST_WQD: begin
        if (rd_empty) begin
          if (bud_zero) begin
            stat_d = 1'b1;
            res_d  = 16'd0;
          end else begin
            budget_d = budget_q - CW'(1);
            mem_re = 1'b1; mem_raddr = q_q + 16'd1;
          end
        end else if (r_gt) begin
          // Split the taken part off the high end of node p.
          mem_we = WE_HI; mem_waddr = p_q; mem_wdata = {r_s[15:0] - p_q, 16'd0};
          rov_d = p_q;
          res_d = r_s[15:0];
        end else if (r_eq) begin
          mem_re = 1'b1; mem_raddr = p_q + 16'd1;
        end else begin
          mem_we = WE_HI; mem_waddr = p_q; mem_wdata = {q_q - p_q, 16'd0};
          mem_re = 1'b1; mem_raddr = p_q + 16'd1;
        end
      end
      ST_WM2: begin
        // Unlink the empty node q that follows p.
        if (q_q == rov_q) begin
          rov_d = rd_lo;
        end
        t_d = rd_lo;
        l_d = rd_hi;
        mem_we = WE_HI; mem_waddr = rd_lo + 16'd1; mem_wdata = {rd_hi, 16'd0};
      end
      ST_WM3: begin
        mem_we = WE_LO; mem_waddr = l_q + 16'd1; mem_wdata = {16'd0, t_q};
      end
      ST_WM4: begin
        mem_re = 1'b1; mem_raddr = q_q;
      end
      ST_WMQ: q_d = q_q + rd_hi;
      ST_WEQ: begin
        if (rp_ne) begin
          // The whole node is taken and leaves the ring.
          rov_d = rd_lo;
          t_d   = rd_hi;
          res_d = p_q;
          mem_we = WE_HI; mem_waddr = rd_lo + 16'd1; mem_wdata = {rd_hi, 16'd0};
        end else begin
          mem_we = WE_HI; mem_waddr = p_q; mem_wdata = {q_q - p_q, 16'd0};
          mem_re = 1'b1; mem_raddr = p_q + 16'd1;
        end
      end
      ST_WEQ2: begin
        mem_we = WE_LO; mem_waddr = t_q + 16'd1; mem_wdata = {16'd0, rov_q};
      end
      ST_WNX: begin
        p_d = rd_lo;
        if (bud_zero) begin
          stat_d = 1'b1;
          res_d  = 16'd0;
        end else begin
          budget_d = budget_q - CW'(1);
        end
      end
      ST_GFND: begin
        mem_we = WE_LO; mem_waddr = res_q;
        vc_d = vc_q + {1'b0, s_q};
      end
      ST_GR0: begin
        if (grow_ok) begin
          t_d = tgt[15:0];
          mem_re = 1'b1; mem_raddr = rov_q + 16'd1;
        end else begin
          stat_d = 1'b1;
          res_d  = 16'd0;
        end
      end
      ST_GR1: begin
        p_d = rd_hi;
        mem_we = WE_LO; mem_waddr = rd_hi + 16'd1; mem_wdata = {16'd0, lb_q};
      end
      ST_GR2: begin
        mem_we = WE_HI; mem_waddr = rov_q + 16'd1; mem_wdata = {lb_q, 16'd0};
      end
      ST_GR3: begin
        mem_we = WE_ALL; mem_waddr = lb_q + 16'd1; mem_wdata = {p_q, rov_q};
      end
      ST_GR4: begin
        mem_we = WE_ALL; mem_waddr = lb_q; mem_wdata = {t_q - lb_q, EMPTY_MARK};
      end
      ST_GR5: begin
        mem_we = WE_ALL; mem_waddr = t_q;
        rov_d = lb_q;
        lb_d  = t_q;
      end
      ST_S0: begin
        mem_re = 1'b1; mem_raddr = rov_q + 16'd1;
      end
      ST_S1: begin
        // Open the ring after the rover; the list is rebuilt in address order.
        p_d   = rd_lo;
        old_d = rov_q;
        ins_d = CW'(1);
        outer_d = '0;
        mem_we = WE_LO; mem_waddr = rov_q + 16'd1; mem_wdata = {16'd0, HALF_MAX};
      end
      ST_S2: begin
        if (p_q != old_q) begin
          outer_d = outer_q + CW'(1);
          if (outer_over) begin
            stat_d = 1'b1;
          end else if (p_q < rov_q) begin
            q_d = p_q;
            mem_re = 1'b1; mem_raddr = p_q + 16'd1;
          end else begin
            q_d = rov_q;
            n_d = '0;
            mem_re = 1'b1; mem_raddr = rov_q + 16'd1;
          end
        end
      end
      ST_SLT: begin
        mem_we = WE_LO; mem_waddr = q_q + 16'd1; mem_wdata = {16'd0, rov_q};
        rov_d = q_q;
        p_d   = rd_lo;
        ins_d = ins_q + CW'(1);
      end
      ST_SIN: begin
        if (rd_lo < p_q) begin
          if (n_over) begin
            stat_d = 1'b1;
          end else begin
            n_d = n_q + CW'(1);
            q_d = rd_lo;
            mem_re = 1'b1; mem_raddr = rd_lo + 16'd1;
          end
        end else begin
          t_d = rd_lo;
          mem_re = 1'b1; mem_raddr = p_q + 16'd1;
        end
      end
      ST_SIN2: begin
        l_d = rd_lo;
        mem_we = WE_LO; mem_waddr = p_q + 16'd1; mem_wdata = {16'd0, t_q};
      end
      ST_SIN3: begin
        mem_we = WE_LO; mem_waddr = q_q + 16'd1; mem_wdata = {16'd0, p_q};
        p_d   = l_q;
        ins_d = ins_q + CW'(1);
      end
      ST_SF0: begin
        p_d = rov_q;
        n_d = '0;
        mem_re = 1'b1; mem_raddr = rov_q + 16'd1;
      end
      ST_SF1: begin
        if (rd_lo != HALF_MAX) begin
          if (n_over) begin
            stat_d = 1'b1;
          end else begin
            n_d = n_q + CW'(1);
            mem_we = WE_HI; mem_waddr = rd_lo + 16'd1; mem_wdata = {p_q, 16'd0};
            p_d = rd_lo;
          end
        end else begin
          mem_we = WE_LO; mem_waddr = p_q + 16'd1; mem_wdata = {16'd0, rov_q};
        end
      end
      ST_SF2: begin
        mem_re = 1'b1; mem_raddr = p_q + 16'd1;
      end
      ST_SF3: begin
        mem_we = WE_HI; mem_waddr = rov_q + 16'd1; mem_wdata = {p_q, 16'd0};
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      lst_q       <= 12'd19;
      hsb_q       <= 16'd61426;
      stop_q      <= 16'd61439;
      hsu_q       <= 8'd14;
      avail_q     <= 16'd0;
      top_q       <= 16'd61439;
      lb_q        <= 16'd0;
      hb_q        <= 16'd61426;
      rov_q       <= 16'd0;
      vc_q        <= 17'd0;
      sc_q        <= 17'd0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      avail_q <= avail_d;
      top_q   <= top_d;
      lb_q    <= lb_d;
      hb_q    <= hb_d;
      rov_q   <= rov_d;
      vc_q    <= vc_d;
      sc_q    <= sc_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOW_TOP:   lst_q  <= cfg_wdata_i[11:0];
          CFG_HIGH_BOT:  hsb_q  <= cfg_wdata_i;
          CFG_STORE_TOP: stop_q <= cfg_wdata_i;
          CFG_HIGH_USE:  hsu_q  <= cfg_wdata_i[7:0];
          default:       lst_q  <= lst_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d; a_q <= a_d; p_q <= p_d; q_q <= q_d; t_q <= t_d; l_q <= l_d;
    k_q <= k_d; old_q <= old_d; res_q <= res_d; sort_q <= sort_d; stat_q <= stat_d;
    budget_q <= budget_d; outer_q <= outer_d; ins_q <= ins_d; n_q <= n_d;
    if (out_load) begin
      out_res_q  <= res_q;
      out_stat_q <= stat_q;
      out_vc_q   <= vc_q;
      out_sc_q   <= sc_q;
    end
  end

  assign in_stall_o      = state_q != ST_IDLE;
  assign out_valid_o     = out_valid_q;
  assign result_addr_o   = out_res_q;
  assign status_o        = out_stat_q;
  assign variable_used_o = out_vc_q;
  assign single_used_o   = out_sc_q;

  // The sequencer never reads and writes the same store word in one cycle.
  a_no_rw_same : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_re && (mem_we != WE_NONE)) |-> (ix(mem_raddr) != ix(mem_waddr)))
    else $error("store read and write collide on one word");

  // A new result only ever comes out of the final sequencer state.
  a_load_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside the final state");

  // An overflow answer never carries an address.
  a_fail_no_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stat_q) |-> (out_res_q == 16'd0))
    else $error("overflow result carries an address");

endmodule

`default_nettype wire

[verif/tena_checker.sv]
// Scoreboard for the two-ended node allocator: mirrors the word store and the
// pointers, predicts one result per accepted request and compares it.
// Depends on tena_pkg; instantiated by tb_top beside the block.
`timescale 1ns / 1ps

module tena_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [15:0] node_words_i,
  input  wire logic [15:0] node_addr_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [15:0] result_addr_i,
  input  wire logic        status_i,
  input  wire logic [16:0] variable_used_i,
  input  wire logic [16:0] single_used_i,
  input  wire logic        drain_i,
  output int               fails_o
);
  import tena_pkg::*;

  localparam int unsigned GROW_WORDS = 1000;
  localparam longint MERGE_ONLY = 1073741824;

  typedef struct packed {
    logic [15:0] addr;
    logic        overflow;
    logic [16:0] var_words;
    logic [16:0] single_words;
  } alloc_result_t;

  alloc_result_t pending_results[$];

  bit [31:0] words [0:65535];
  bit [15:0] low_top, high_bot, store_top_r;
  bit [7:0]  high_use;
  bit [15:0] avail, top_end, lo_bnd, hi_bnd, rover;
  bit [16:0] var_cnt, one_cnt;

  initial fails_o = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fails_o++;
  endtask

  function automatic bit [15:0] link_of(bit [15:0] a);
    return words[a][15:0];
  endfunction
  function automatic bit [15:0] info_of(bit [15:0] a);
    return words[a][31:16];
  endfunction
  function automatic void set_link(bit [15:0] a, bit [15:0] v);
    words[a][15:0] = v;
  endfunction
  function automatic void set_info(bit [15:0] a, bit [15:0] v);
    words[a][31:16] = v;
  endfunction
  // A free node keeps its left neighbor in the info half and its right
  // neighbor in the link half of its second word.
  function automatic bit [15:0] left_of(bit [15:0] p);
    return info_of(p + 16'd1);
  endfunction
  function automatic bit [15:0] right_of(bit [15:0] p);
    return link_of(p + 16'd1);
  endfunction
  function automatic void set_left(bit [15:0] p, bit [15:0] v);
    set_info(p + 16'd1, v);
  endfunction
  function automatic void set_right(bit [15:0] p, bit [15:0] v);
    set_link(p + 16'd1, v);
  endfunction

  // First-fit pass from the rover: 0 found, 1 no fit, 2 runaway ring.
  function automatic int walk_free_ring(longint need, output bit [15:0] found);
    int unsigned budget;
    bit [15:0] p, q, t;
    longint r;
    budget = 131072;
    found = 0;
    p = rover;
    do begin
      q = p + info_of(p);
      while (link_of(q) == EMPTY_MARK) begin
        if (budget == 0) return 2;
        budget--;
        t = right_of(q);
        if (q == rover) rover = t;
        set_left(t, left_of(q));
        set_right(left_of(q), t);
        q = q + info_of(q);
      end
      r = longint'(q) - need;
      if (r > longint'(p) + 1) begin
        set_info(p, 16'(r - longint'(p)));
        rover = p;
        found = 16'(r);
        return 0;
      end
      if (r == longint'(p) && right_of(p) != p) begin
        rover = right_of(p);
        t = left_of(p);
        set_left(rover, t);
        set_right(t, rover);
        found = 16'(r);
        return 0;
      end
      set_info(p, q - p);
      p = right_of(p);
      if (budget == 0) return 2;
      budget--;
    end while (p != rover);
    return 1;
  endfunction

  function automatic bit take_node(bit [15:0] need, output bit [15:0] found);
    int st;
    longint lo, hi, t;
    bit [15:0] p, q;
    forever begin
      lo = lo_bnd;
      hi = hi_bnd;
      st = walk_free_ring(longint'(need), found);
      if (st == 0) begin
        set_link(found, 16'd0);
        var_cnt = var_cnt + 17'(need);
        return 1;
      end
      if (st == 2) return 0;
      if (!(lo + 2 < hi && lo + 2 <= 65535)) return 0;
      // Grow the low region by a chunk, or by half the gap when it is tight.
      if (lo + GROW_WORDS < hi) t = lo + GROW_WORDS;
      else t = (lo + hi + 2) / 2;
      if (t > 65535) t = 65535;
      p = left_of(rover);
      q = lo_bnd;
      set_right(p, q);
      set_left(rover, q);
      set_right(q, rover);
      set_left(q, p);
      set_link(q, EMPTY_MARK);
      set_info(q, 16'(t - lo));
      lo_bnd = 16'(t);
      words[lo_bnd] = 0;
      rover = q;
    end
  endfunction

  // Insertion sort of the free ring by address, after a merge-only walk.
  function automatic bit sort_free_ring();
    bit [15:0] p, q, r, old;
    int unsigned inserted, outer, n;
    inserted = 1;
    outer = 0;
    if (walk_free_ring(MERGE_ONLY, r) == 2) return 0;
    p = right_of(rover);
    set_right(rover, HALF_MAX);
    old = rover;
    while (p != old) begin
      outer++;
      if (outer > 65536) return 0;
      if (p < rover) begin
        q = p;
        p = right_of(q);
        set_right(q, rover);
        rover = q;
      end else begin
        q = rover;
        n = 0;
        while (right_of(q) < p) begin
          n++;
          if (n > inserted) return 0;
          q = right_of(q);
        end
        r = right_of(p);
        set_right(p, right_of(q));
        set_right(q, p);
        p = r;
      end
      inserted++;
    end
    p = rover;
    n = 0;
    while (right_of(p) != HALF_MAX) begin
      n++;
      if (n > inserted) return 0;
      set_left(right_of(p), p);
      p = right_of(p);
    end
    set_right(p, rover);
    set_left(rover, p);
    return 1;
  endfunction

  function automatic void init_store();
    bit [15:0] rv;
    rv = low_top + 16'd1;
    for (int k = 0; k <= int'(low_top); k++) words[k] = 0;
    rover = rv;
    set_link(rv, EMPTY_MARK);
    set_info(rv, 16'(GROW_WORDS));
    set_left(rv, rv);
    set_right(rv, rv);
    lo_bnd = rv + 16'(GROW_WORDS);
    words[lo_bnd] = 0;
    for (int k = int'(high_bot); k <= int'(store_top_r); k++) words[k] = 0;
    avail = 0;
    top_end = store_top_r;
    hi_bnd = high_bot;
    var_cnt = 17'(low_top) + 17'd1;
    one_cnt = 17'(high_use);
  endfunction

  function automatic alloc_result_t predict_request(logic [2:0] req, logic [15:0] size_in,
                                                    logic [15:0] addr);
    alloc_result_t res;
    bit [15:0] size, p, q;
    res = '0;
    size = (size_in < 16'd2) ? 16'd2 : size_in;
    case (req)
      REQ_INIT: init_store();
      REQ_GET1: begin
        p = avail;
        if (p != 0) begin
          avail = link_of(p);
        end else if (top_end < 16'hFFFF) begin
          top_end = top_end + 16'd1;
          p = top_end;
        end else if (int'(hi_bnd) - 1 <= int'(lo_bnd)) begin
          res.overflow = 1'b1;
        end else begin
          hi_bnd = hi_bnd - 16'd1;
          p = hi_bnd;
        end
        if (!res.overflow) begin
          set_link(p, 16'd0);
          one_cnt = one_cnt + 17'd1;
          res.addr = p;
        end
      end
      REQ_GETV: begin
        if (!take_node(size, p)) begin
          res.overflow = 1'b1;
        end else begin
          res.addr = p;
        end
      end
      REQ_FREEV: begin
        set_info(addr, size);
        set_link(addr, EMPTY_MARK);
        q = left_of(rover);
        set_left(addr, q);
        set_right(addr, rover);
        set_left(rover, addr);
        set_right(q, addr);
        var_cnt = var_cnt - 17'(size);
      end
      REQ_FREE1: begin
        set_link(addr, avail);
        avail = addr;
        one_cnt = one_cnt - 17'd1;
      end
      REQ_SORT: res.overflow = !sort_free_ring();
      default: ;
    endcase
    res.var_words = var_cnt;
    res.single_words = one_cnt;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    if (!rst_ni) begin
      pending_results.delete();
      low_top = 16'd19;
      high_bot = 16'd61426;
      store_top_r = 16'd61439;
      high_use = 8'd14;
      avail = 0;
      top_end = store_top_r;
      lo_bnd = 0;
      hi_bnd = high_bot;
      rover = 0;
      var_cnt = 0;
      one_cnt = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOW_TOP:   low_top = {4'd0, cfg_wdata_i[11:0]};
          CFG_HIGH_BOT:  high_bot = cfg_wdata_i;
          CFG_STORE_TOP: store_top_r = cfg_wdata_i;
          CFG_HIGH_USE:  high_use = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        pending_results.push_back(predict_request(req_type_i, node_words_i, node_addr_i));
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report("unexpected transaction", 32'(result_addr_i), 0);
        end else begin
          want = pending_results.pop_front();
          if (result_addr_i !== want.addr)
            report("result_addr", 32'(result_addr_i), 32'(want.addr));
          if (status_i !== want.overflow)
            report("status", 32'(status_i), 32'(want.overflow));
          if (variable_used_i !== want.var_words)
            report("variable_used", 32'(variable_used_i), 32'(want.var_words));
          if (single_used_i !== want.single_words)
            report("single_used", 32'(single_used_i), 32'(want.single_words));
        end
      end
    end
  end

  // Anything still waiting when the run drains was never answered.
  always @(posedge drain_i)
    if (pending_results.size() != 0)
      report("results never delivered", 32'(pending_results.size()), 0);

endmodule

[verif/tb_top.sv]
// Top of the allocator testbench: clock, reset, register writes, request
// stimulus and result-side stalling; tena_checker does all the checking.
// Depends on tena_pkg, tena_checker and two_ended_node_allocator.
`timescale 1ns / 1ps

module tb_top;
  import tena_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_LOW_TOP;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  req_type_i = REQ_INIT;
  logic [15:0] node_words_i = '0;
  logic [15:0] node_addr_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] result_addr_o;
  logic        status_o;
  logic [16:0] variable_used_o;
  logic [16:0] single_used_o;
  logic        drain = 1'b0;
  int          fails;

  // Random idling on both channels can be switched off for a quiet stretch,
  // and the receiver can be held off entirely to back the block up.
  bit idle_on = 1'b1;
  bit hold_off = 1'b0;

  typedef struct {
    logic [2:0]  req;
    logic [15:0] size;
  } sent_req_t;

  typedef struct {
    logic [15:0] addr;
    logic [15:0] size;
  } live_node_t;

  // Requests still waiting for their result, and what the block has handed
  // out so far: only addresses that came back are ever freed, so the block
  // never reads a word that was not written first.
  sent_req_t  in_flight[$];
  logic [15:0] live_singles[$];
  live_node_t  live_nodes[$];

  always #4 clk_i = ~clk_i;

  two_ended_node_allocator uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .req_type_i, .node_words_i, .node_addr_i,
    .out_valid_o, .out_stall_i, .result_addr_o, .status_o,
    .variable_used_o, .single_used_o
  );

  tena_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .req_type_i, .node_words_i, .node_addr_i,
    .out_valid_i(out_valid_o), .out_stall_i, .result_addr_i(result_addr_o),
    .status_i(status_o), .variable_used_i(variable_used_o),
    .single_used_i(single_used_o), .drain_i(drain), .fails_o(fails)
  );

  // The receiver stalls about a quarter of the time unless told otherwise.
  always @(negedge clk_i)
    out_stall_i <= hold_off || (idle_on && $urandom_range(99) < 25);

  // Track handed-out words and nodes from each delivered result.
  always @(posedge clk_i) begin
    sent_req_t sent;
    if (rst_ni && out_valid_o && !out_stall_i && in_flight.size() != 0) begin
      sent = in_flight.pop_front();
      if (!status_o && sent.req == REQ_GET1) live_singles.push_back(result_addr_o);
      if (!status_o && sent.req == REQ_GETV) live_nodes.push_back('{result_addr_o, sent.size});
    end
  end

  // Offers one request and returns at the falling edge after it is accepted.
  // Valid stays high afterwards so back-to-back requests need no extra edge.
  task automatic send(input logic [2:0] req, input logic [15:0] size, input logic [15:0] addr);
    while (idle_on && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    node_words_i <= size;
    node_addr_i <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    in_flight.push_back('{req, size});
    @(negedge clk_i);
  endtask

  // Lets every result come back and then waits on for good measure.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (in_flight.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // Writes all four registers while the block is idle, then starts over with
  // an init so the bookkeeping of live words and nodes is empty again.
  task automatic reconfigure(input logic [15:0] low_top, input logic [15:0] high_bot,
                             input logic [15:0] store_top, input logic [15:0] high_use);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_LOW_TOP;
    cfg_wdata_i <= low_top;
    @(negedge clk_i);
    cfg_idx_i <= CFG_HIGH_BOT;
    cfg_wdata_i <= high_bot;
    @(negedge clk_i);
    cfg_idx_i <= CFG_STORE_TOP;
    cfg_wdata_i <= store_top;
    @(negedge clk_i);
    cfg_idx_i <= CFG_HIGH_USE;
    cfg_wdata_i <= high_use;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    live_singles.delete();
    live_nodes.delete();
    send(REQ_INIT, 16'($urandom), 16'($urandom));
  endtask

  task automatic free_some_node();
    int k;
    live_node_t n;
    k = $urandom_range(live_nodes.size() - 1);
    n = live_nodes[k];
    live_nodes.delete(k);
    send(REQ_FREEV, n.size, n.addr);
  endtask

  task automatic free_some_single();
    int k;
    logic [15:0] a;
    k = $urandom_range(live_singles.size() - 1);
    a = live_singles[k];
    live_singles.delete(k);
    send(REQ_FREE1, 16'($urandom), a);
  endtask

  // Mostly well-formed traffic: nodes of small sizes, frees of what came
  // back, an occasional sort, oversized request or unused request code.
  task automatic random_traffic(input int count);
    int pick;
    logic [15:0] size;
    for (int i = 0; i < count; i++) begin
      if (i == count / 3) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(negedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      idle_on = !(i > count / 2 && i < count / 2 + 60);
      pick = $urandom_range(99);
      size = ($urandom_range(9) == 0) ? 16'($urandom_range(41, 3000))
                                      : 16'($urandom_range(0, 40));
      if (live_nodes.size() > 40) pick = 40;
      if (pick < 1) begin
        send(REQ_GETV, 16'($urandom_range(32768, 65535)), 16'($urandom));
      end else if (pick < 28) begin
        send(REQ_GETV, size, 16'($urandom));
      end else if (pick < 50) begin
        if (live_nodes.size() != 0) free_some_node();
        else send(REQ_GETV, size, 16'($urandom));
      end else if (pick < 68) begin
        send(REQ_GET1, 16'($urandom), 16'($urandom));
      end else if (pick < 85) begin
        if (live_singles.size() != 0) free_some_single();
        else send(REQ_GET1, 16'($urandom), 16'($urandom));
      end else if (pick < 87) begin
        send(REQ_SORT, 16'($urandom), 16'($urandom));
      end else if (pick < 88) begin
        send(3'($urandom_range(6, 7)), 16'($urandom), 16'($urandom));
      end else begin
        send(REQ_GETV, size, 16'($urandom));
      end
    end
  endtask

  // Directed opening, then random phases under several register settings.
  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    reconfigure(16'd19, 16'd61426, 16'd61439, 16'd14);
    send(REQ_GET1, 16'h0000, 16'hFFFF);
    send(REQ_GET1, 16'hFFFF, 16'h0000);
    send(REQ_GETV, 16'd0, 16'd0);
    send(REQ_GETV, 16'd1, 16'd0);
    send(REQ_GETV, 16'd2, 16'd0);
    send(REQ_GETV, 16'd1000, 16'd0);   // too large for the first node: grows
    send(REQ_SORT, 16'd0, 16'd0);
    send(3'd6, 16'hFFFF, 16'hFFFF);
    send(3'd7, 16'h5555, 16'hAAAA);
    wait_idle();
    while (live_nodes.size() != 0) free_some_node();
    while (live_singles.size() != 0) free_some_single();
    send(REQ_SORT, 16'd0, 16'd0);
    send(REQ_GET1, 16'd0, 16'd0);       // comes back off the free-word stack

    // Store top at the end and the high region just above the low one: single
    // words come from the high boundary until it meets the low one and the
    // request overflows; an oversized node then has no room to grow either.
    reconfigure(16'd1, 16'd1024, 16'd65535, 16'd255);
    repeat (24) send(REQ_GET1, 16'd0, 16'd0);
    send(REQ_GETV, 16'd65535, 16'd0);
    send(REQ_GETV, 16'd3, 16'd0);

    reconfigure(16'd19, 16'd61426, 16'd61439, 16'd14);
    random_traffic(250);
    reconfigure(16'd4095, 16'd9000, 16'd9100, 16'd100);
    random_traffic(150);
    reconfigure(16'd1, 16'd65535, 16'd65535, 16'd0);
    random_traffic(200);

    wait_idle();
    drain <= 1'b1;
    repeat (3) @(negedge clk_i);
    if (fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
